// ----- rtl/core/tcha_pkg.sv -----
// Shared types and constants for the three-channel hysteresis alarm.
// No dependencies; imported by every module of the block.
`default_nettype none
package tcha_pkg;

    // Channel and overall status codes.
    typedef enum logic [1:0] {
        LVL_NORMAL  = 2'd0,
        LVL_WARNING = 2'd1,
        LVL_ERROR   = 2'd2
    } t_level;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TEMP_LIMITS  = 2'd0;
    localparam logic [1:0] CFG_PRESS_LIMITS = 2'd1;
    localparam logic [1:0] CFG_HUMID_LIMITS = 2'd2;
    localparam logic [1:0] CFG_HYSTERESIS   = 2'd3;

    // Input command codes.
    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_SILENCE = 1'b1;

    localparam int SAMPLE_W = 16;
    localparam int LIMITS_W = 64;
    localparam int HYST_W   = 12;
    localparam int CMP_W    = 17;

    // Overall alarm indication derived from the three channel levels.
    typedef struct packed {
        t_level worst;
        logic   red;
        logic   yellow;
        logic   green;
        logic   buzzer;
    } t_alarm;

endpackage
`default_nettype wire

// ----- rtl/core/tcha_chan.sv -----
// Next-level logic for one sensor channel: four thresholds and hysteresis.
// Depends on tcha_pkg.
`default_nettype none
module tcha_chan
    import tcha_pkg::*;
(
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic        [LIMITS_W-1:0] i_limits,
    input  wire logic        [HYST_W-1:0]   i_hyst,
    input  wire t_level                     i_cur,
    output t_level                          o_next
);

    logic signed [CMP_W-1:0] v, h;
    logic signed [CMP_W-1:0] min_err, min_wrn, max_wrn, max_err;
    logic hit_err, hit_wrn, hold_err, hold_wrn;

    // All compares are done in 17 bits so that limit +/- hysteresis never wraps.
    assign v       = CMP_W'(i_sample);
    assign h       = $signed({{(CMP_W-HYST_W){1'b0}}, i_hyst});
    assign min_err = CMP_W'($signed(i_limits[15:0]));
    assign min_wrn = CMP_W'($signed(i_limits[31:16]));
    assign max_wrn = CMP_W'($signed(i_limits[47:32]));
    assign max_err = CMP_W'($signed(i_limits[63:48]));

    assign hit_err  = (v >= max_err) || (v <= min_err);
    assign hit_wrn  = (v >= max_wrn) || (v <= min_wrn);
    assign hold_err = (v >= max_err - h) || (v <= min_err + h);
    assign hold_wrn = (v >= max_wrn - h) || (v <= min_wrn + h);

    always_comb begin
        case (i_cur)
            LVL_ERROR: begin
                if (hold_err)     o_next = LVL_ERROR;
                else if (hit_wrn) o_next = LVL_WARNING;
                else              o_next = LVL_NORMAL;
            end
            LVL_WARNING: begin
                if (hit_err)       o_next = LVL_ERROR;
                else if (hold_wrn) o_next = LVL_WARNING;
                else               o_next = LVL_NORMAL;
            end
            default: begin
                // Normal, and the unused code three, which behaves as normal.
                if (hit_err)      o_next = LVL_ERROR;
                else if (hit_wrn) o_next = LVL_WARNING;
                else              o_next = LVL_NORMAL;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/tcha_alarm.sv -----
// Worst-level selection, lamp decode and buzzer arming logic.
// Depends on tcha_pkg.
`default_nettype none
module tcha_alarm
    import tcha_pkg::*;
(
    input  wire t_level i_temp,
    input  wire t_level i_press,
    input  wire t_level i_humid,
    input  wire logic   i_silence,
    input  wire logic   i_armed,
    output t_alarm      o_alarm,
    output logic        o_armed_next
);

    t_level worst_tp;
    t_level worst;

    assign worst_tp = (i_press > i_temp) ? i_press : i_temp;
    assign worst    = (i_humid > worst_tp) ? i_humid : worst_tp;

    always_comb begin
        if (i_silence)                o_armed_next = 1'b0;
        else if (worst != LVL_ERROR)  o_armed_next = 1'b1;
        else                          o_armed_next = i_armed;
    end

    always_comb begin
        o_alarm.worst  = worst;
        o_alarm.red    = (worst == LVL_ERROR);
        o_alarm.yellow = (worst == LVL_WARNING);
        o_alarm.green  = (worst != LVL_ERROR) && (worst != LVL_WARNING);
        o_alarm.buzzer = (worst == LVL_ERROR) && o_armed_next;
    end

endmodule
`default_nettype wire

// ----- rtl/core/three_channel_hysteresis_alarm_core.sv -----
// Top level of the three-channel hysteresis alarm: input, state and result registers.
// Depends on tcha_pkg, tcha_chan and tcha_alarm.
//
// The input channel (i_valid / o_ready) carries one request per transfer: either a
// sensor sample (i_cmd = 0) with temperature, pressure and humidity readings in
// signed Q11.4, or a buzzer-silence command (i_cmd = 1). Every request produces
// exactly one result on the output channel (o_valid / i_ready): three channel
// levels, the worst level, the lamps and the buzzer.
// A request accepted at a clock edge sits in the input register, and the channel
// update, worst-level and lamp logic place its result in the result register when
// that stage advances, where o_valid rises. One request is taken every cycle as
// long as the receiver takes results; the channel state and the buzzer arming flag
// update with the result register, so back-to-back samples see each other's state.
// When the receiver stalls, the result register holds its contents and the input
// register still accepts one more request; o_ready drops only when both are full.
// The configuration channel (i_cfg_valid / o_cfg_ready) is always ready and writes
// the three packed limit words and the hysteresis; it should only be used while no
// request is in flight. Synchronous reset clears both pipeline stages, sets every
// channel to normal, arms the buzzer and zeroes all limits and the hysteresis.
`default_nettype none
module three_channel_hysteresis_alarm_core
    import tcha_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Configuration write channel.
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [1:0]                 i_cfg_index,
    input  wire logic [LIMITS_W-1:0]        i_cfg_data,
    // Request channel.
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_cmd,
    input  wire logic signed [SAMPLE_W-1:0] i_temp_sample,
    input  wire logic signed [SAMPLE_W-1:0] i_press_sample,
    input  wire logic signed [SAMPLE_W-1:0] i_humid_sample,
    // Result channel.
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [1:0]                      o_temp_level,
    output logic [1:0]                      o_press_level,
    output logic [1:0]                      o_humid_level,
    output logic [1:0]                      o_worst_level,
    output logic                            o_red_lamp,
    output logic                            o_yellow_lamp,
    output logic                            o_green_lamp,
    output logic                            o_buzzer
);

    // Configuration registers.
    logic [LIMITS_W-1:0] r_temp_limits, r_press_limits, r_humid_limits;
    logic [HYST_W-1:0]   r_hyst;

    // Input register stage.
    logic                       r_in_valid;
    logic                       r_in_cmd;
    logic signed [SAMPLE_W-1:0] r_in_temp, r_in_press, r_in_humid;

    // Channel state and buzzer arming.
    t_level r_temp_state, r_press_state, r_humid_state;
    logic   r_armed;

    // Result register stage.
    logic   r_out_valid;
    t_level r_out_temp, r_out_press, r_out_humid;
    t_alarm r_out_alarm;

    t_level n_temp_state, n_press_state, n_humid_state;
    t_level lvl_temp, lvl_press, lvl_humid;
    logic   n_armed;
    t_alarm alarm;
    logic   silence;
    logic   fire;

    // The result stage advances on a held request when empty or its result is taken.
    assign fire        = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;
    assign silence     = (r_in_cmd == CMD_SILENCE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_limits  <= '0;
            r_press_limits <= '0;
            r_humid_limits <= '0;
            r_hyst         <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TEMP_LIMITS:  r_temp_limits  <= i_cfg_data;
                CFG_PRESS_LIMITS: r_press_limits <= i_cfg_data;
                CFG_HUMID_LIMITS: r_humid_limits <= i_cfg_data;
                CFG_HYSTERESIS:   r_hyst         <= i_cfg_data[HYST_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_cmd   <= i_cmd;
            r_in_temp  <= i_temp_sample;
            r_in_press <= i_press_sample;
            r_in_humid <= i_humid_sample;
        end
    end

    tcha_chan u_temp (
        .i_sample (r_in_temp),
        .i_limits (r_temp_limits),
        .i_hyst   (r_hyst),
        .i_cur    (r_temp_state),
        .o_next   (n_temp_state)
    );

    tcha_chan u_press (
        .i_sample (r_in_press),
        .i_limits (r_press_limits),
        .i_hyst   (r_hyst),
        .i_cur    (r_press_state),
        .o_next   (n_press_state)
    );

    tcha_chan u_humid (
        .i_sample (r_in_humid),
        .i_limits (r_humid_limits),
        .i_hyst   (r_hyst),
        .i_cur    (r_humid_state),
        .o_next   (n_humid_state)
    );

    // A silence command leaves the channel levels where they are.
    assign lvl_temp  = silence ? r_temp_state  : n_temp_state;
    assign lvl_press = silence ? r_press_state : n_press_state;
    assign lvl_humid = silence ? r_humid_state : n_humid_state;

    tcha_alarm u_alarm (
        .i_temp       (lvl_temp),
        .i_press      (lvl_press),
        .i_humid      (lvl_humid),
        .i_silence    (silence),
        .i_armed      (r_armed),
        .o_alarm      (alarm),
        .o_armed_next (n_armed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_state  <= LVL_NORMAL;
            r_press_state <= LVL_NORMAL;
            r_humid_state <= LVL_NORMAL;
            r_armed       <= 1'b1;
        end else if (fire) begin
            r_temp_state  <= lvl_temp;
            r_press_state <= lvl_press;
            r_humid_state <= lvl_humid;
            r_armed       <= n_armed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_temp  <= lvl_temp;
            r_out_press <= lvl_press;
            r_out_humid <= lvl_humid;
            r_out_alarm <= alarm;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_temp_level  = r_out_temp;
    assign o_press_level = r_out_press;
    assign o_humid_level = r_out_humid;
    assign o_worst_level = r_out_alarm.worst;
    assign o_red_lamp    = r_out_alarm.red;
    assign o_yellow_lamp = r_out_alarm.yellow;
    assign o_green_lamp  = r_out_alarm.green;
    assign o_buzzer      = r_out_alarm.buzzer;

endmodule
`default_nettype wire

// ----- rtl/core/tcha_checker.sv -----
// Port-level assertions for the three-channel hysteresis alarm core.
// Depends on tcha_pkg; bound to three_channel_hysteresis_alarm_core below.
`default_nettype none
module tcha_checker
    import tcha_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [1:0] o_temp_level,
    input wire logic [1:0] o_press_level,
    input wire logic [1:0] o_humid_level,
    input wire logic [1:0] o_worst_level,
    input wire logic       o_red_lamp,
    input wire logic       o_yellow_lamp,
    input wire logic       o_green_lamp,
    input wire logic       o_buzzer
);

    // A stalled result stays valid and keeps its worst level and buzzer.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_worst_level) && $stable(o_buzzer))
        else $error("stalled result changed");

    // Exactly one lamp is lit, and it matches the worst level.
    a_lamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot({o_red_lamp, o_yellow_lamp, o_green_lamp})
                    && (o_red_lamp == (o_worst_level == LVL_ERROR))
                    && (o_yellow_lamp == (o_worst_level == LVL_WARNING)))
        else $error("lamp decode does not match worst level");

    // The buzzer only sounds with the red lamp.
    a_buzz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_buzzer |-> o_red_lamp)
        else $error("buzzer on without error level");

    // The worst level is the largest of the channel levels and one of them.
    a_worst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_worst_level >= o_temp_level) && (o_worst_level >= o_press_level)
                    && (o_worst_level >= o_humid_level)
                    && ((o_worst_level == o_temp_level) || (o_worst_level == o_press_level)
                        || (o_worst_level == o_humid_level)))
        else $error("worst level is not the channel maximum");

endmodule

bind three_channel_hysteresis_alarm_core tcha_checker u_tcha_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_temp_level  (o_temp_level),
    .o_press_level (o_press_level),
    .o_humid_level (o_humid_level),
    .o_worst_level (o_worst_level),
    .o_red_lamp    (o_red_lamp),
    .o_yellow_lamp (o_yellow_lamp),
    .o_green_lamp  (o_green_lamp),
    .o_buzzer      (o_buzzer)
);
`default_nettype wire
